// ===== rtl/core/share_lockin_run_detector_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Share lock-in run detector: assertion macros
// Shared property forms for the checker; clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SHARE_LOCKIN_RUN_DETECTOR_UNIT_ASSERT_SVH
`define SHARE_LOCKIN_RUN_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SLRD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slrd assertion failed");

// Next-cycle implication.
`define SLRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slrd assertion failed");

`endif

// ===== rtl/core/slrd_pkg.sv =====
// ----------------------------------------------------------------------------
// slrd_pkg
// Types and constants shared by the share lock-in run detector.
// ----------------------------------------------------------------------------
package slrd_pkg;

  localparam int NUM_TECHS  = 4;
  localparam int RUN_W      = 16;
  localparam int SHARE_W    = 16;
  localparam int PERSIST_W  = 15;
  localparam int ACTIVE_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LOCK_W     = 2;
  localparam int CMP_W      = (RUN_W > PERSIST_W + 1) ? RUN_W : PERSIST_W + 1;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  localparam logic [SHARE_W-1:0]   THRESHOLD_RST = SHARE_W'(26214);
  localparam logic [PERSIST_W-1:0] PERSIST_RST   = PERSIST_W'(10);
  localparam logic [ACTIVE_W-1:0]  ACTIVE_RST    = ACTIVE_W'(4);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHARE_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE_STEPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TECHS      = 2'd2;

  typedef enum logic [LOCK_W-1:0] {
    LOCK_NONE    = 2'd0,
    LOCK_PARTIAL = 2'd1,
    LOCK_FULL    = 2'd2
  } lock_state_t;

  typedef logic [NUM_TECHS-1:0][SHARE_W-1:0] share_vec_t;
  typedef logic [NUM_TECHS-1:0][RUN_W-1:0]   run_vec_t;

  // Per-step control broadcast to every lane
  typedef struct packed {
    logic adv;    // a step is taken this cycle
    logic clear;  // the step closes the series
  } lane_ctrl_t;

endpackage

// ===== rtl/core/slrd_lane.sv =====
// ----------------------------------------------------------------------------
// slrd_lane
// Run counter of one technology lane: threshold compare and saturating count.
// ----------------------------------------------------------------------------
module slrd_lane (
  input  logic                               clk,
  input  logic                               rst_n,
  input  slrd_pkg::lane_ctrl_t               ctrl,
  input  logic                               active,
  input  logic [slrd_pkg::SHARE_W-1:0]       share,
  input  logic [slrd_pkg::SHARE_W-1:0]       threshold,
  output logic [slrd_pkg::RUN_W-1:0]         cnt_nxt
);

  logic [slrd_pkg::RUN_W-1:0] cnt_r;
  logic                       qual;

  always_comb begin
    qual = active && (share >= threshold);
    if (!qual) begin
      cnt_nxt = '0;
    end else if (cnt_r == slrd_pkg::RUN_MAX) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // advance on every step; drop the run when the series closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.adv) begin
      cnt_r <= ctrl.clear ? '0 : cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/slrd_verdict.sv =====
// ----------------------------------------------------------------------------
// slrd_verdict
// Longest-run update over all lanes and the lock-state decision.
// ----------------------------------------------------------------------------
module slrd_verdict (
  input  slrd_pkg::run_vec_t                 cnt_nxt,
  input  logic [slrd_pkg::RUN_W-1:0]         best_r,
  input  logic [slrd_pkg::PERSIST_W-1:0]     persist,
  output logic [slrd_pkg::RUN_W-1:0]         best_nxt,
  output slrd_pkg::lock_state_t              lock
);

  logic [slrd_pkg::CMP_W-1:0] best_ext;
  logic [slrd_pkg::CMP_W-1:0] full_lvl;
  logic [slrd_pkg::CMP_W-1:0] part_lvl;

  always_comb begin
    best_nxt = best_r;
    for (int i = 0; i < slrd_pkg::NUM_TECHS; i++) begin
      if (cnt_nxt[i] > best_nxt) begin
        best_nxt = cnt_nxt[i];
      end
    end
  end

  always_comb begin
    best_ext = slrd_pkg::CMP_W'(best_nxt);
    full_lvl = slrd_pkg::CMP_W'({persist, 1'b0});
    part_lvl = slrd_pkg::CMP_W'(persist);
    if (best_nxt == '0) begin
      lock = slrd_pkg::LOCK_NONE;
    end else if (best_ext >= full_lvl) begin
      lock = slrd_pkg::LOCK_FULL;
    end else if (best_ext >= part_lvl) begin
      lock = slrd_pkg::LOCK_PARTIAL;
    end else begin
      lock = slrd_pkg::LOCK_NONE;
    end
  end

endmodule

// ===== rtl/core/share_lockin_run_detector_unit.sv =====
// ----------------------------------------------------------------------------
// share_lockin_run_detector_unit
// Tracks per-technology runs of steps at or above a share threshold and
// reports the lock state and longest run on the last step of each series.
//
//   channel  | handshake          | word
//   ---------+--------------------+------------------------------------------
//   in       | in_valid/in_stall  | four Q1.15 shares, last-step mark
//   out      | out_valid/out_stall| lock state, longest run (last step only)
//   cfg      | cfg_we             | threshold, persistence, active lanes
//
// One step is accepted every cycle unless in_stall is high. A step is
// held in the input register; as it leaves, the lane counters and the
// longest run update, and a last step loads the result register at the
// same edge, from which its result word is offered until it is taken.
// The result register is the only buffer on the output side: a last step
// waits in the input register while an earlier result is stalled, and other
// steps keep flowing. Reset (rst_n low, synchronous) clears all runs and
// loads the default configuration; there is no clearing pass.
// ----------------------------------------------------------------------------
module share_lockin_run_detector_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input words
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [slrd_pkg::SHARE_W-1:0]          in_share_tech_0,
  input  logic [slrd_pkg::SHARE_W-1:0]          in_share_tech_1,
  input  logic [slrd_pkg::SHARE_W-1:0]          in_share_tech_2,
  input  logic [slrd_pkg::SHARE_W-1:0]          in_share_tech_3,
  input  logic                                  in_last_step,
  // result words
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [slrd_pkg::LOCK_W-1:0]           out_lock_state,
  output logic [slrd_pkg::RUN_W-1:0]            out_longest_run,
  // configuration
  input  logic                                  cfg_we,
  input  logic [slrd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [slrd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  // configuration registers
  logic [slrd_pkg::SHARE_W-1:0]   threshold_r;
  logic [slrd_pkg::PERSIST_W-1:0] persist_r;
  logic [slrd_pkg::ACTIVE_W-1:0]  active_r;

  // input register
  logic                 s1_valid_r;
  slrd_pkg::share_vec_t s1_share_r;
  logic                 s1_last_r;

  // series state and result register
  logic [slrd_pkg::RUN_W-1:0]  best_r;
  logic [slrd_pkg::RUN_W-1:0]  best_nxt;
  logic                        out_valid_r;
  slrd_pkg::lock_state_t       out_lock_r;
  logic [slrd_pkg::RUN_W-1:0]  out_run_r;

  logic                        slot_free;
  logic                        s1_fire;
  slrd_pkg::lane_ctrl_t        lane_ctrl;
  logic [slrd_pkg::NUM_TECHS-1:0] lane_active;
  slrd_pkg::run_vec_t          cnt_nxt;
  slrd_pkg::lock_state_t       lock;

  // --------------------------------------------------------------------------
  // Configuration writes; index 3 is not a register and is dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= slrd_pkg::THRESHOLD_RST;
      persist_r   <= slrd_pkg::PERSIST_RST;
      active_r    <= slrd_pkg::ACTIVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        slrd_pkg::CFG_SHARE_THRESHOLD: begin
          threshold_r <= cfg_wdata[slrd_pkg::SHARE_W-1:0];
        end
        slrd_pkg::CFG_PERSISTENCE_STEPS: begin
          persist_r <= cfg_wdata[slrd_pkg::PERSIST_W-1:0];
        end
        slrd_pkg::CFG_ACTIVE_TECHS: begin
          active_r <= cfg_wdata[slrd_pkg::ACTIVE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: an ordinary step always advances; a last step advances
  // only when the result register can take its word.
  // --------------------------------------------------------------------------
  assign slot_free = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && (!s1_last_r || slot_free);
  assign in_stall  = s1_valid_r && !s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  // hold the word while stalled
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_share_r[0] <= in_share_tech_0;
      s1_share_r[1] <= in_share_tech_1;
      s1_share_r[2] <= in_share_tech_2;
      s1_share_r[3] <= in_share_tech_3;
      s1_last_r     <= in_last_step;
    end
  end

  // --------------------------------------------------------------------------
  // Lanes: a lane takes part when its index is below active_techs; values
  // above the lane count therefore enable all lanes.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < slrd_pkg::NUM_TECHS; i++) begin
      lane_active[i] = (slrd_pkg::ACTIVE_W+1)'(i) < {1'b0, active_r};
    end
  end

  assign lane_ctrl.adv   = s1_fire;
  assign lane_ctrl.clear = s1_last_r;

  for (genvar g = 0; g < slrd_pkg::NUM_TECHS; g++) begin : g_lane
    slrd_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (lane_ctrl),
      .active    (lane_active[g]),
      .share     (s1_share_r[g]),
      .threshold (threshold_r),
      .cnt_nxt   (cnt_nxt[g])
    );
  end

  slrd_verdict u_verdict (
    .cnt_nxt  (cnt_nxt),
    .best_r   (best_r),
    .persist  (persist_r),
    .best_nxt (best_nxt),
    .lock     (lock)
  );

  // Longest run of the series; cleared once the verdict is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (s1_fire) begin
      best_r <= s1_last_r ? '0 : best_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= s1_fire && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && s1_fire && s1_last_r) begin
      out_lock_r <= lock;
      out_run_r  <= best_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lock_state  = out_lock_r;
  assign out_longest_run = out_run_r;

endmodule

// ===== rtl/core/slrd_checker.sv =====
// ----------------------------------------------------------------------------
// slrd_checker
// Port-level checks on the result channel of the run detector.
// ----------------------------------------------------------------------------
`include "share_lockin_run_detector_unit_assert.svh"

module slrd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [slrd_pkg::LOCK_W-1:0]       out_lock_state,
  input logic [slrd_pkg::RUN_W-1:0]        out_longest_run
);

  // a stalled result stays up and keeps its word
  `SLRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `SLRD_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
                    $stable(out_lock_state) && $stable(out_longest_run))
  // no qualifying step means no lock
  `SLRD_ASSERT_NOW(a_zero_run_unlocked, out_valid && (out_longest_run == '0),
                   out_lock_state == slrd_pkg::LOCK_NONE)
  // only the three lock codes appear
  `SLRD_ASSERT_NOW(a_lock_code, out_valid,
                   (out_lock_state == slrd_pkg::LOCK_NONE) ||
                   (out_lock_state == slrd_pkg::LOCK_PARTIAL) ||
                   (out_lock_state == slrd_pkg::LOCK_FULL))
  // no result is offered and no input word is stalled right out of reset
  `SLRD_ASSERT_NOW(a_reset_empty, $rose(rst_n), !out_valid && !(in_valid && in_stall))

endmodule

bind share_lockin_run_detector_unit slrd_checker u_slrd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_lock_state  (out_lock_state),
  .out_longest_run (out_longest_run)
);

// ===== tb/sv/share_lockin_run_checker.sv =====
// ----------------------------------------------------------------------------
// Share lock-in run checker
// Watches the step, result and register ports of the run detector, keeps its
// own copy of the lane runs and settings, and compares every result word.
// ----------------------------------------------------------------------------
module share_lockin_run_checker
  import slrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [SHARE_W-1:0]    in_share_tech_0,
  input  logic [SHARE_W-1:0]    in_share_tech_1,
  input  logic [SHARE_W-1:0]    in_share_tech_2,
  input  logic [SHARE_W-1:0]    in_share_tech_3,
  input  logic                  in_last_step,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [LOCK_W-1:0]     out_lock_state,
  input  logic [RUN_W-1:0]      out_longest_run,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    failures,
  output int                    outstanding
);

  typedef struct packed {
    lock_state_t       lock;
    logic [RUN_W-1:0]  run;
  } lockin_verdict_t;

  lockin_verdict_t      pending_verdicts[$];
  logic [SHARE_W-1:0]   threshold;
  logic [PERSIST_W-1:0] persistence;
  logic [ACTIVE_W-1:0]  active_lanes;
  run_vec_t             lane_run;
  logic [RUN_W-1:0]     series_best;
  int                   error_count;

  // Zero best run is never a lock, whatever the persistence.
  function automatic lock_state_t grade_series(logic [RUN_W-1:0] best,
                                               logic [PERSIST_W-1:0] persist);
    logic [PERSIST_W:0] twice;
    twice = {persist, 1'b0};
    if (best == '0) return LOCK_NONE;
    if ({1'b0, best} >= {1'b0, twice}) return LOCK_FULL;
    if (best >= persist) return LOCK_PARTIAL;
    return LOCK_NONE;
  endfunction

  task automatic clear_series();
    lane_run    = '0;
    series_best = '0;
  endtask

  // Advance every lane by one step; a closing step queues its verdict.
  task automatic advance_runs(share_vec_t shares, logic closing);
    int lanes;
    lanes = (active_lanes > NUM_TECHS) ? NUM_TECHS : int'(active_lanes);
    for (int i = 0; i < NUM_TECHS; i++) begin
      if (i < lanes && shares[i] >= threshold) begin
        if (lane_run[i] != RUN_MAX) lane_run[i] = lane_run[i] + 1'b1;
        if (lane_run[i] > series_best) series_best = lane_run[i];
      end else begin
        lane_run[i] = '0;
      end
    end
    if (closing) begin
      pending_verdicts.push_back('{grade_series(series_best, persistence), series_best});
      clear_series();
    end
  endtask

  always @(posedge clk) begin
    lockin_verdict_t want;
    if (!rst_n) begin
      threshold    = THRESHOLD_RST;
      persistence  = PERSIST_RST;
      active_lanes = ACTIVE_RST;
      clear_series();
      pending_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          if (error_count < 10)
            $display("unexpected result word: lock_state %0d longest_run %0d",
                     out_lock_state, out_longest_run);
          error_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_lock_state !== want.lock || out_longest_run !== want.run) begin
            if (error_count < 10)
              $display("mismatch: lock_state exp %0d got %0d, longest_run exp %0d got %0d",
                       want.lock, out_lock_state, want.run, out_longest_run);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        advance_runs({in_share_tech_3, in_share_tech_2, in_share_tech_1, in_share_tech_0},
                     in_last_step);
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHARE_THRESHOLD:   threshold    = cfg_wdata[SHARE_W-1:0];
          CFG_PERSISTENCE_STEPS: persistence  = cfg_wdata[PERSIST_W-1:0];
          CFG_ACTIVE_TECHS:      active_lanes = cfg_wdata[ACTIVE_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= pending_verdicts.size();
    failures    <= error_count;
  end

endmodule

// ===== tb/sv/tb_share_lockin_run_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Share lock-in run detector testbench
// Drives series of share steps through the detector under a range of
// threshold, persistence and active-lane settings, with bursty input and a
// stalling receiver; the checker beside the block scores every result word.
// ----------------------------------------------------------------------------
module tb_share_lockin_run_detector_unit;
  import slrd_pkg::*;

  localparam int CYCLE_LIMIT   = 700000;
  localparam int RANDOM_STEPS  = 900;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [SHARE_W-1:0]    in_share_tech_0;
  logic [SHARE_W-1:0]    in_share_tech_1;
  logic [SHARE_W-1:0]    in_share_tech_2;
  logic [SHARE_W-1:0]    in_share_tech_3;
  logic                  in_last_step;
  logic                  out_valid;
  logic                  out_stall;
  logic [LOCK_W-1:0]     out_lock_state;
  logic [RUN_W-1:0]      out_longest_run;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int                    run_failures;
  int                    results_owed;
  int                    cycle_count;

  // Stimulus-side view of the settings, used to aim shares at the threshold and to scale series lengths
  logic [SHARE_W-1:0]    cur_thr;
  logic [PERSIST_W-1:0]  cur_persist;
  int                    burst_left;
  bit                    gapless;
  bit                    pressure_go;

  share_lockin_run_detector_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_share_tech_0 (in_share_tech_0),
    .in_share_tech_1 (in_share_tech_1),
    .in_share_tech_2 (in_share_tech_2),
    .in_share_tech_3 (in_share_tech_3),
    .in_last_step    (in_last_step),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_lock_state  (out_lock_state),
    .out_longest_run (out_longest_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  share_lockin_run_checker lockin_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_share_tech_0 (in_share_tech_0),
    .in_share_tech_1 (in_share_tech_1),
    .in_share_tech_2 (in_share_tech_2),
    .in_share_tech_3 (in_share_tech_3),
    .in_last_step    (in_last_step),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_lock_state  (out_lock_state),
    .out_longest_run (out_longest_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .failures        (run_failures),
    .outstanding     (results_owed)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: segments of free flow, random stalls, alternating stalls and
  // heavy stalls. Once the stimulus asks for it, hold off for a long stretch
  // so the result register and the input register both fill.
  initial begin : stall_pattern
    int mode;
    int span;
    bit held_off;
    out_stall = 1'b0;
    held_off  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (pressure_go && !held_off) begin
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
        held_off = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(1, 40);
        for (int k = 0; k < span; k++) begin
          @(posedge clk);
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= k[0];
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // Offer one step word and hold it until accepted. Between bursts, drop
  // valid for a random gap; gapless mode streams back to back.
  task automatic send_step(input logic [SHARE_W-1:0] s0, input logic [SHARE_W-1:0] s1,
                           input logic [SHARE_W-1:0] s2, input logic [SHARE_W-1:0] s3,
                           input logic last);
    if (!gapless && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    in_valid        <= 1'b1;
    in_share_tech_0 <= s0;
    in_share_tech_1 <= s1;
    in_share_tech_2 <= s2;
    in_share_tech_3 <= s3;
    in_last_step    <= last;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
  endtask

  // Drop valid and wait until every result has come back, then let the
  // pipeline settle so that steps that produce no result retire.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Reprogram all three registers once the block has gone quiet.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] thr_word,
                               input logic [CFG_DATA_W-1:0] persist_word,
                               input logic [CFG_DATA_W-1:0] active_word);
    wait_idle();
    write_reg(CFG_SHARE_THRESHOLD, thr_word);
    write_reg(CFG_PERSISTENCE_STEPS, persist_word);
    write_reg(CFG_ACTIVE_TECHS, active_word);
    cfg_we      <= 1'b0;
    cur_thr     = thr_word[SHARE_W-1:0];
    cur_persist = persist_word[PERSIST_W-1:0];
  endtask

  // Pick a share on the chosen side of the threshold, leaning on the edge
  // values and on shares above 1.0.
  function automatic logic [SHARE_W-1:0] pick_share(input bit above);
    int r;
    r = $urandom_range(0, 7);
    if (above || cur_thr == '0) begin
      case (r)
        0, 1:          return cur_thr;
        2, 3, 4, 5:    return (cur_thr <= 32768) ? SHARE_W'($urandom_range(32768, cur_thr))
                                                 : cur_thr;
        6:             return SHARE_W'($urandom_range(65535, cur_thr));
        default:       return '1;
      endcase
    end
    case (r)
      0, 1:            return cur_thr - 1'b1;
      2, 3, 4, 5, 6:   return SHARE_W'($urandom_range(cur_thr - 1, 0));
      default:         return '0;
    endcase
  endfunction

  // One series closed by a last step. Lanes are sticky above or below the
  // threshold so runs build up; now and then a series is pure noise.
  task automatic send_series(input int len);
    bit                 lane_hi[NUM_TECHS];
    logic [SHARE_W-1:0] s[NUM_TECHS];
    bit                 noisy;
    noisy = ($urandom_range(0, 5) == 0);
    foreach (lane_hi[i]) lane_hi[i] = ($urandom_range(0, 2) != 0);
    for (int k = 0; k < len; k++) begin
      foreach (s[i]) begin
        if (k > 0 && $urandom_range(0, 5) == 0) lane_hi[i] = !lane_hi[i];
        s[i] = noisy ? SHARE_W'($urandom_range(0, 65535)) : pick_share(lane_hi[i]);
      end
      send_step(s[0], s[1], s[2], s[3], k == len - 1);
    end
  endtask

  initial begin : stimulus
    int random_steps;
    int phase;
    int phase_target;
    int phase_steps;
    int len;
    int r;
    logic [CFG_DATA_W-1:0] thr_word;
    logic [CFG_DATA_W-1:0] persist_word;
    logic [CFG_DATA_W-1:0] active_word;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_share_tech_0 = '0;
    in_share_tech_1 = '0;
    in_share_tech_2 = '0;
    in_share_tech_3 = '0;
    in_last_step    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    cur_thr         = THRESHOLD_RST;
    cur_persist     = PERSIST_RST;
    burst_left      = 0;
    gapless         = 1'b0;
    pressure_go     = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a lone last step with nothing qualifying, then a short
    // run with shares at and above 1.0, at the threshold and just below it.
    send_step(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    send_step(16'd32768, 16'hFFFF, 16'd26214, 16'd26213, 1'b0);
    send_step(16'd32768, 16'hFFFF, 16'd26214, 16'd26213, 1'b1);

    // Zero persistence (upper data bit must be ignored): nothing qualifying
    // stays unlocked, a single qualifying step is already a full lock.
    apply_setting(16'd32768, 16'h8000, 16'd4);
    send_step(16'd32767, 16'd0, 16'd1, 16'd0, 1'b1);
    send_step(16'd32768, 16'd0, 16'd0, 16'd0, 1'b1);

    // No active lanes: threshold zero still gives no run.
    apply_setting(16'd0, 16'd0, 16'hFFF8);
    send_step(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);

    // Active count above the lane count acts as all lanes.
    apply_setting(16'd0, 16'd5, 16'd7);
    send_step(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);

    // Single lane: inactive lanes sit above threshold but must not count;
    // lane 0 breaks once and restarts its run.
    apply_setting(16'd32768, 16'd1, 16'd1);
    send_step(16'd32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_step(16'd32767, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_step(16'd32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_step(16'd32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

    // Two lanes, persistence three: a run of exactly three is a partial lock.
    apply_setting(16'd32768, 16'h8003, 16'd2);
    send_step(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
    send_step(16'd0, 16'd32768, 16'd0, 16'hFFFF, 1'b0);
    send_step(16'd0, 16'hFFFF, 16'd0, 16'd0, 1'b1);

    // Random phases: a fresh setting per phase, then series of random length
    // scaled to the persistence so all three verdicts show up. Some phases
    // stream back to back.
    random_steps = 0;
    phase        = 0;
    while (random_steps < RANDOM_STEPS) begin
      r = $urandom_range(0, 5);
      thr_word = (r == 0) ? 16'd0 : (r == 1) ? 16'd32768 : (r == 2) ? THRESHOLD_RST
                                  : CFG_DATA_W'($urandom_range(0, 32768));
      r = $urandom_range(0, 9);
      persist_word = (r == 0) ? 16'd0 : (r == 1) ? 16'd1 : (r == 2) ? 16'd32767
                                      : CFG_DATA_W'($urandom_range(2, 8));
      persist_word[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
      active_word = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 7))
                                                : CFG_DATA_W'($urandom_range(1, 4));
      active_word[CFG_DATA_W-1:ACTIVE_W] = (CFG_DATA_W - ACTIVE_W)'($urandom);
      apply_setting(thr_word, persist_word, active_word);
      gapless = ($urandom_range(0, 3) == 0);

      // Start the long receiver hold-off while this phase is streaming.
      if (phase == 1) pressure_go = 1'b1;

      phase_target = $urandom_range(80, 160);
      phase_steps  = 0;
      while (phase_steps < phase_target) begin
        len = (2 * int'(cur_persist) + 4 < 30) ? 2 * int'(cur_persist) + 4 : 30;
        len = $urandom_range(1, len);
        send_series(len);
        phase_steps += len;
      end
      gapless = 1'b0;
      random_steps += phase_steps;
      phase++;
    end

    wait_idle();
    if (run_failures == 0 && results_owed == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
